@@ sv/caps_layer_key_remapper_macros.svh @@
`ifndef CAPS_LAYER_KEY_REMAPPER_MACROS_SVH
`define CAPS_LAYER_KEY_REMAPPER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CLKR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define CLKR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/clkr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package clkr_pkg;

  localparam int MAX_HELD_DEF = 8;

  localparam logic [7:0] CAPS_CODE_RESET = 8'd20;

  localparam logic [7:0] CODE_V = 8'h56;
  localparam logic [7:0] CODE_H = 8'h48;
  localparam logic [7:0] CODE_J = 8'h4A;
  localparam logic [7:0] CODE_K = 8'h4B;
  localparam logic [7:0] CODE_L = 8'h4C;

  localparam logic [2:0] EMIT_NONE   = 3'd0;
  localparam logic [2:0] EMIT_LEFT   = 3'd1;
  localparam logic [2:0] EMIT_DOWN   = 3'd2;
  localparam logic [2:0] EMIT_UP     = 3'd3;
  localparam logic [2:0] EMIT_RIGHT  = 3'd4;
  localparam logic [2:0] EMIT_ESCAPE = 3'd5;

  typedef struct packed {
    logic [7:0] key_code;
    logic       pressed;
  } clkr_in_t;

  typedef struct packed {
    logic       consumed;
    logic [2:0] emit_key;
  } clkr_out_t;

endpackage

`default_nettype wire

@@ sv/clkr_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module clkr_core #(
  parameter int MaxHeld = clkr_pkg::MAX_HELD_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  clkr_pkg::clkr_in_t  item_i,
  input  logic [7:0]          caps_code_i,
  output clkr_pkg::clkr_out_t result_o
);
  import clkr_pkg::*;

  localparam int CntW = $clog2(MaxHeld + 1);
  localparam int IdxW = $clog2(MaxHeld);

  logic [7:0]         list_q [MaxHeld];
  logic [7:0]         list_d [MaxHeld];
  logic [7:0]         rem    [MaxHeld];
  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    count_d;
  logic [MaxHeld-1:0] match;
  logic [MaxHeld-1:0] after;
  logic               found;
  logic               is_caps;
  logic               hit_v;
  logic [2:0]         dir;

  for (genvar i = 0; i < MaxHeld; i++) begin : g_slot
    assign match[i] = (CntW'(i) < count_q) && (list_q[i] == item_i.key_code);
    assign after[i] = |match[i:0];
    if (i < MaxHeld - 1) begin : g_shift
      assign rem[i] = after[i] ? list_q[i+1] : list_q[i];
    end else begin : g_last
      assign rem[i] = list_q[i];
    end
  end

  assign found   = |match;
  assign is_caps = (item_i.key_code == caps_code_i);
  assign hit_v   = (count_q == CntW'(2)) && (list_q[1] == CODE_V);

  always_comb begin
    case (item_i.key_code)
      CODE_H:  dir = EMIT_LEFT;
      CODE_J:  dir = EMIT_DOWN;
      CODE_K:  dir = EMIT_UP;
      CODE_L:  dir = EMIT_RIGHT;
      default: dir = EMIT_NONE;
    endcase
  end

  always_comb begin
    list_d            = list_q;
    count_d           = count_q;
    result_o.consumed = 1'b0;
    result_o.emit_key = EMIT_NONE;
    if (item_i.pressed) begin
      result_o.consumed = hit_v || (count_q != '0) || is_caps;
      if (hit_v) begin
        result_o.emit_key = dir;
      end
      if (hit_v && (dir != EMIT_NONE)) begin
        list_d  = rem;
        count_d = count_q - CntW'(found);
      end else if (((count_q != '0) || is_caps) && !found &&
                   (count_q < CntW'(MaxHeld))) begin
        list_d[count_q[IdxW-1:0]] = item_i.key_code;
        count_d = count_q + CntW'(1);
      end
    end else if (is_caps) begin
      count_d           = '0;
      result_o.consumed = 1'b1;
      result_o.emit_key = (count_q == CntW'(1)) ? EMIT_ESCAPE : EMIT_NONE;
    end else begin
      list_d  = rem;
      count_d = count_q - CntW'(found);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (step_i) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      list_q <= list_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/caps_layer_key_remapper.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  payload             handshake
// in       input      key_code, pressed   in_valid_i / in_ready_o
// out      output     consumed, emit_key  out_valid_o / out_ready_i
// cfg      input      caps_key_code       cfg_we_i (no wait)
//
// One item per cycle sustained while out_ready_i allows; each item passes through the
// input register and then the result register.
// The held list and its count update in the cycle the item leaves the input register.
// Reset empties the list and sets the caps code to 20.
// A stalled output holds the result; the input register takes an item while it
// is empty or while its item moves on to the result register.

module caps_layer_key_remapper #(
  parameter int MaxHeld = clkr_pkg::MAX_HELD_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  clkr_pkg::clkr_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output clkr_pkg::clkr_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);
  import clkr_pkg::*;

  logic       s1_valid_q;
  logic       s1_valid_d;
  clkr_in_t   s1_data_q;
  logic       out_valid_q;
  logic       out_valid_d;
  clkr_out_t  out_data_q;
  clkr_out_t  result;
  logic [7:0] caps_q;
  logic       advance;
  logic       in_take;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  clkr_core #(
    .MaxHeld(MaxHeld)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (s1_data_q),
    .caps_code_i(caps_q),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      caps_q      <= CAPS_CODE_RESET;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        caps_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ sv/caps_layer_key_remapper_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "caps_layer_key_remapper_macros.svh"

module caps_layer_key_remapper_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input clkr_pkg::clkr_out_t out_data_o
);
  import clkr_pkg::*;

  `CLKR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "out item dropped")
  `CLKR_ASSERT_NOW(a_emit_range, out_valid_o, out_data_o.emit_key <= EMIT_ESCAPE, "bad emit")
  `CLKR_ASSERT_NOW(a_emit_cons, out_valid_o && (out_data_o.emit_key != EMIT_NONE),
                   out_data_o.consumed, "emit without consume")
  `CLKR_ASSERT_NOW(a_ready_free, !out_valid_o, in_ready_o, "input stalled with empty output")
  `CLKR_ASSERT_NEXT(a_take_shows, in_valid_i && in_ready_o && !out_valid_o,
                    1'b1 ##1 out_valid_o, "accepted item never shown")

endmodule

bind caps_layer_key_remapper caps_layer_key_remapper_checker u_checker (.*);

`default_nettype wire

@@ test/caps_layer_key_remapper_test.sv @@
`timescale 1ns / 1ps

module caps_layer_key_remapper_test;
  import clkr_pkg::*;

  localparam int unsigned HELD_MAX = MAX_HELD_DEF;

  typedef struct packed {
    logic [7:0] key;
    logic       press;
    logic       typed;
    clkr_out_t  want;
  } key_row_t;

  localparam key_row_t KEY_SCRIPT [23] = '{
    '{8'h41,           1'b1, 1'b1, '{1'b0, EMIT_NONE}},
    '{8'h41,           1'b0, 1'b1, '{1'b0, EMIT_NONE}},
    '{CAPS_CODE_RESET, 1'b1, 1'b1, '{1'b1, EMIT_NONE}},
    '{CAPS_CODE_RESET, 1'b0, 1'b1, '{1'b1, EMIT_ESCAPE}},
    '{CAPS_CODE_RESET, 1'b1, 1'b0, '{1'b0, EMIT_NONE}},
    '{CODE_V,          1'b1, 1'b0, '{1'b0, EMIT_NONE}},
    '{CODE_H,          1'b1, 1'b1, '{1'b1, EMIT_LEFT}},
    '{CODE_J,          1'b1, 1'b1, '{1'b1, EMIT_DOWN}},
    '{CODE_K,          1'b1, 1'b1, '{1'b1, EMIT_UP}},
    '{CODE_L,          1'b1, 1'b1, '{1'b1, EMIT_RIGHT}},
    '{CODE_V,          1'b1, 1'b0, '{1'b0, EMIT_NONE}},
    '{8'hFF,           1'b1, 1'b0, '{1'b0, EMIT_NONE}},
    '{CODE_H,          1'b1, 1'b0, '{1'b0, EMIT_NONE}},
    '{CODE_V,          1'b0, 1'b0, '{1'b0, EMIT_NONE}},
    '{8'h00,           1'b1, 1'b0, '{1'b0, EMIT_NONE}},
    '{8'h01,           1'b1, 1'b0, '{1'b0, EMIT_NONE}},
    '{8'h80,           1'b1, 1'b0, '{1'b0, EMIT_NONE}},
    '{8'h7F,           1'b1, 1'b0, '{1'b0, EMIT_NONE}},
    '{8'h55,           1'b1, 1'b0, '{1'b0, EMIT_NONE}},
    '{8'hAA,           1'b1, 1'b0, '{1'b0, EMIT_NONE}},
    '{8'hAA,           1'b0, 1'b0, '{1'b0, EMIT_NONE}},
    '{CAPS_CODE_RESET, 1'b0, 1'b1, '{1'b1, EMIT_NONE}},
    '{8'hFF,           1'b1, 1'b1, '{1'b0, EMIT_NONE}}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  clkr_in_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  clkr_out_t  out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  logic [7:0]  held_keys [HELD_MAX];
  int unsigned held_n = 0;
  logic [7:0]  caps_code = CAPS_CODE_RESET;

  clkr_out_t   expect_q [$];
  int unsigned mismatches = 0;
  int unsigned keys_sent = 0;
  bit          steady = 1'b0;

  caps_layer_key_remapper u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic void drop_held(input logic [7:0] key);
    int unsigned w;
    w = 0;
    for (int unsigned i = 0; i < held_n; i++) begin
      if (held_keys[i] != key) begin
        held_keys[w] = held_keys[i];
        w++;
      end
    end
    held_n = w;
  endfunction

  function automatic clkr_out_t remap_event(input clkr_in_t ev);
    clkr_out_t   r;
    int unsigned n;
    bit          dup;
    n = held_n;
    r.consumed = 1'b0;
    r.emit_key = EMIT_NONE;
    if (ev.pressed) begin
      if (n > 0 || ev.key_code == caps_code) begin
        dup = 1'b0;
        for (int unsigned i = 0; i < held_n; i++) begin
          if (held_keys[i] == ev.key_code) dup = 1'b1;
        end
        if (!dup && held_n < HELD_MAX) begin
          held_keys[held_n] = ev.key_code;
          held_n++;
        end
      end
      if (n == 2 && held_keys[1] == CODE_V) begin
        case (ev.key_code)
          CODE_H: r.emit_key = EMIT_LEFT;
          CODE_J: r.emit_key = EMIT_DOWN;
          CODE_K: r.emit_key = EMIT_UP;
          CODE_L: r.emit_key = EMIT_RIGHT;
          default: r.emit_key = EMIT_NONE;
        endcase
        if (r.emit_key != EMIT_NONE) drop_held(ev.key_code);
        r.consumed = 1'b1;
      end else if (held_n > 0) begin
        r.consumed = 1'b1;
      end
    end else if (ev.key_code == caps_code) begin
      held_n = 0;
      if (n == 1) r.emit_key = EMIT_ESCAPE;
      r.consumed = 1'b1;
    end else begin
      drop_held(ev.key_code);
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_arrow();
    case ($urandom_range(0, 3))
      0: return CODE_H;
      1: return CODE_J;
      2: return CODE_K;
      default: return CODE_L;
    endcase
  endfunction

  task automatic send_key(input logic [7:0] key, input logic press,
                          input logic typed = 1'b0, input clkr_out_t want = '0);
    int unsigned gap;
    clkr_out_t   predicted;
    clkr_in_t    ev;
    gap = steady ? 0 : $urandom_range(0, 18);
    ev.key_code = key;
    ev.pressed = press;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = remap_event(ev);
    expect_q.insert(expect_q.size(), typed ? want : predicted);
    keys_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_caps(input logic [7:0] code);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= code;
    @(negedge clk);
    cfg_we <= 1'b0;
    caps_code = code;
  endtask

  task automatic play_phase(input int unsigned budget);
    int unsigned stop_at;
    int unsigned reps;
    logic [7:0]  k;
    stop_at = keys_sent + budget;
    while (keys_sent < stop_at) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) begin
        send_key(caps_code, 1'b1);
        if ($urandom_range(0, 5) == 0) send_key(caps_code, 1'b1);
        send_key(($urandom_range(0, 4) != 0) ? CODE_V : 8'($urandom_range(0, 255)), 1'b1);
        reps = $urandom_range(1, 5);
        repeat (reps) begin
          k = ($urandom_range(0, 4) != 0) ? pick_arrow() : 8'($urandom_range(0, 255));
          send_key(k, 1'b1);
          if ($urandom_range(0, 2) == 0) send_key(k, 1'b0);
        end
        if ($urandom_range(0, 4) == 0) begin
          reps = $urandom_range(3, 10);
          repeat (reps) send_key(8'($urandom_range(0, 255)), 1'b1);
        end
        if ($urandom_range(0, 1) == 0) send_key(CODE_V, 1'b0);
        if ($urandom_range(0, 9) != 0) send_key(caps_code, 1'b0);
      end else begin
        reps = $urandom_range(1, 4);
        repeat (reps) send_key(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    clkr_out_t   want;
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 18);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expect_q.size() == 0) begin
        $error("unexpected result: consumed %0d emit_key %0d",
               out_data.consumed, out_data.emit_key);
        mismatches++;
      end else begin
        want = expect_q.pop_front();
        if (out_data.consumed !== want.consumed) begin
          $error("consumed: expected %0d, got %0d", want.consumed, out_data.consumed);
          mismatches++;
        end
        if (out_data.emit_key !== want.emit_key) begin
          $error("emit_key: expected %0d, got %0d", want.emit_key, out_data.emit_key);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 23; i++) begin
      send_key(KEY_SCRIPT[i].key, KEY_SCRIPT[i].press, KEY_SCRIPT[i].typed,
               KEY_SCRIPT[i].want);
    end
    write_caps(8'h00);
    play_phase(80);
    write_caps(8'hFF);
    play_phase(80);
    write_caps(CODE_V);
    play_phase(80);
    write_caps(8'($urandom_range(1, 254)));
    play_phase(80);
    write_caps(CAPS_CODE_RESET);
    play_phase(80);
    drain();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ caps_layer_key_remapper.f @@
+incdir+sv
sv/clkr_pkg.sv
sv/clkr_core.sv
sv/caps_layer_key_remapper.sv
sv/caps_layer_key_remapper_checker.sv
test/caps_layer_key_remapper_test.sv
